### rtl/core/sfi_pkg.sv
// Shared types and constants of the sampled function interpolator.
package sfi_pkg;

	localparam int NUM_COORDS  = 4;
	localparam int SLOT_W      = 12;
	localparam int SIZE_W      = 16;
	localparam int WORD_W      = 32;
	localparam int IN_DATA_W   = 224;
	localparam int OUT_DATA_W  = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int QUEUE_DEPTH = 4;

	// sample positions and block sizes saturate at 2^40
	localparam int POS_W = 41;
	localparam logic [POS_W-1:0] POS_CAP = 41'h100_0000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_BPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOUT = 2'd2;

	typedef enum logic [1:0] {
		FN_SAMPLE = 2'd0,
		FN_DIM    = 2'd1,
		FN_OUT    = 2'd2,
		FN_EVAL   = 2'd3
	} func_t;

	typedef struct packed {
		func_t                                func;
		logic [SLOT_W-1:0]                    slot;
		logic [SIZE_W-1:0]                    size;
		logic [WORD_W-1:0]                    coef_a;
		logic [WORD_W-1:0]                    coef_b;
		logic [NUM_COORDS-1:0][WORD_W-1:0]    coord;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        channel;
		logic [WORD_W-1:0] value;
		logic              last;
		logic              error;
	} res_t;

endpackage

### rtl/core/sfi_front.sv
// Input side: unpacks words, drops writes to slots that do not exist, feeds the queue.
module sfi_front #(
	parameter int MAX_DIMS     = 4,
	parameter int MAX_CHANNELS = 4,
	parameter int SAMPLE_WORDS = 4096
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sfi_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [1:0]                    s_tuser,
	input  sfi_pkg::q_stat_t              q_stat,
	output logic                          push,
	output sfi_pkg::cmd_t                 cmd
);
	import sfi_pkg::*;

	logic keep;

	always_comb begin
		cmd.func   = func_t'(s_tuser);
		cmd.slot   = s_tdata[11:0];
		cmd.size   = s_tdata[27:12];
		cmd.coef_a = s_tdata[59:28];
		cmd.coef_b = s_tdata[91:60];
		for (int i = 0; i < NUM_COORDS; i++) begin
			cmd.coord[i] = s_tdata[92 + 32*i +: 32];
		end
		case (cmd.func)
			FN_SAMPLE: keep = 32'(cmd.slot) < SAMPLE_WORDS;
			FN_DIM:    keep = 32'(cmd.slot) < MAX_DIMS;
			FN_OUT:    keep = 32'(cmd.slot) < MAX_CHANNELS;
			FN_EVAL:   keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	// out-of-range writes are taken and discarded
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full && keep;

endmodule

### rtl/core/sfi_fifo.sv
// Short command queue between front and back.
module sfi_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfi_pkg::cmd_t    din,
	input  logic             pop,
	output sfi_pkg::cmd_t    dout,
	output sfi_pkg::q_stat_t stat
);
	import sfi_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            buf_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign stat.full  = cnt_q == CW'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

### rtl/core/sfi_back.sv
// Back end: tables, sample memory and the evaluation sequencer.
module sfi_back #(
	parameter int MAX_DIMS     = 4,
	parameter int MAX_CHANNELS = 4,
	parameter int SAMPLE_WORDS = 4096,
	parameter int FRAC_BITS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sfi_pkg::cfg_wr_t cfg,
	input  sfi_pkg::cmd_t    cmd,
	input  sfi_pkg::q_stat_t q_stat,
	output logic             pop,
	output sfi_pkg::res_t    res,
	input  logic             res_ready
);
	import sfi_pkg::*;

	localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ND_W  = $clog2(MAX_DIMS + 1);
	localparam int NO_W  = $clog2(MAX_CHANNELS + 1);
	localparam int AW    = $clog2(SAMPLE_WORDS);
	localparam int LIN_W = 48;
	localparam int BIT_W = 54;
	localparam logic [63:0] TOTAL_BITS = 64'(SAMPLE_WORDS) * 64'd32;
	localparam logic signed [63:0] ACC_LO = -(64'sd1 <<< (FRAC_BITS + 31));
	localparam logic signed [63:0] ACC_HI = (64'sd1 <<< (FRAC_BITS + 32)) - 64'sd1;
	localparam logic signed [63:0] I64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [4:0] {
		S_IDLE, S_MUL, S_ENC, S_POS, S_BLK, S_CH, S_LIN, S_BIT, S_RD, S_EXT,
		S_DIM, S_ZMUL, S_NMUL, S_NADD, S_NEXT, S_DEC1, S_DEC2, S_DEC3, S_DEC4, S_EMIT
	} state_t;

	state_t state_q;

	logic [5:0] bps_q;
	logic [2:0] nin_q, nout_q;

	logic [SIZE_W-1:0] dim_size_q [MAX_DIMS];
	logic [31:0]       dim_gain_q [MAX_DIMS];
	logic [31:0]       dim_off_q  [MAX_DIMS];
	logic [31:0]       out_min_q  [MAX_CHANNELS];
	logic [31:0]       out_gain_q [MAX_CHANNELS];

	logic [31:0] mem [SAMPLE_WORDS];

	logic [DIM_W-1:0] j_q;
	logic [CH_W-1:0]  ch_q;
	logic             nbr_q, err_q;

	cmd_t                     cmd_q;
	logic signed [63:0]       prod_q;
	logic signed [31:0]       enc_q [MAX_DIMS];
	logic [SIZE_W-1:0]        idx_q [MAX_DIMS];
	logic [POS_W-1:0]         blk_q [MAX_DIMS];
	logic [POS_W-1:0]         pos_q, b_q;
	logic [LIN_W-1:0]         lin_q;
	logic [BIT_W-1:0]         bit_q;
	logic                     oob_q, lov_q;
	logic [4:0]               sh_q;
	logic [31:0]              rd_hi_q, rd_lo_q;
	logic [31:0]              sample_q, s2_q;
	logic signed [63:0]       acc_q;
	logic signed [32:0]       eh_q;
	logic [FRAC_BITS-1:0]     el_q;
	logic signed [63:0]       m1_q;
	logic signed [FRAC_BITS+32:0] m2_q;
	logic signed [31:0]       res_q;

	// effective configuration
	logic [5:0]      bps_eff;
	logic [ND_W-1:0] nd_eff;
	logic [NO_W-1:0] no_eff;
	logic            dim_end, ch_end;

	logic              take, emit;
	logic [1:0]        cidx;
	logic [SIZE_W-1:0] size_j, szm1;
	logic signed [31:0] coord_j, gain_j, off_j, ch_gain, ch_min;
	logic signed [63:0] mul_e, off64, e_full;
	logic signed [31:0] e_cl;
	logic [31:0]        e_idx;
	logic [SIZE_W-1:0]  idx_n;
	logic [56:0]        pm, bm;
	logic [POS_W-1:0]   pm_c, bm_c;
	logic [POS_W:0]     pos_sum, p_sel;
	logic [AW-1:0]      rd_a, rd_b;
	logic [63:0]        both, shv;
	logic [31:0]        ext_val;
	logic signed [32:0] enc33, samp33, frac33, diff33;
	logic [63:0]        idx_sh;
	logic signed [63:0] fr64;
	logic signed [65:0] zprod, nprod, m1_full;
	logic signed [64:0] nsum;
	logic signed [63:0] nsat, accc;
	logic signed [FRAC_BITS:0] el_s;
	logic signed [FRAC_BITS+32:0] m2_n;
	logic signed [66:0] r_a, r_b, r_c, r_sum;
	logic signed [31:0] r_cl;

	always_comb begin
		bps_eff = (bps_q == '0) ? 6'd1 : ((bps_q > 6'd32) ? 6'd32 : bps_q);
		nd_eff  = (nin_q == '0) ? ND_W'(1) :
			((32'(nin_q) > MAX_DIMS) ? ND_W'(MAX_DIMS) : ND_W'(nin_q));
		no_eff  = (nout_q == '0) ? NO_W'(1) :
			((32'(nout_q) > MAX_CHANNELS) ? NO_W'(MAX_CHANNELS) : NO_W'(nout_q));
		dim_end = 32'(j_q) == 32'(nd_eff) - 32'd1;
		ch_end  = 32'(ch_q) == 32'(no_eff) - 32'd1;

		take = (state_q == S_IDLE) && !q_stat.empty;
		emit = (state_q == S_EMIT) && (!res.valid || res_ready);

		cidx    = 2'(j_q);
		size_j  = (dim_size_q[j_q] == '0) ? SIZE_W'(1) : dim_size_q[j_q];
		szm1    = size_j - SIZE_W'(1);
		coord_j = (32'(j_q) < NUM_COORDS) ? $signed(cmd_q.coord[cidx]) : 32'sd0;
		gain_j  = $signed(dim_gain_q[j_q]);
		off_j   = $signed(dim_off_q[j_q]);
		ch_gain = $signed(out_gain_q[ch_q]);
		ch_min  = $signed(out_min_q[ch_q]);

		// encode: floor(coord * gain / 2^FRAC_BITS) + offset, saturated to 32 bits
		mul_e  = coord_j * gain_j;
		off64  = off_j;
		e_full = (prod_q >>> FRAC_BITS) + off64;
		if (e_full > 64'sh7fff_ffff) begin
			e_cl = 32'sh7fff_ffff;
		end else if (e_full < -64'sh8000_0000) begin
			e_cl = 32'sh8000_0000;
		end else begin
			e_cl = e_full[31:0];
		end
		e_idx = $unsigned(e_cl) >> FRAC_BITS;
		if (e_cl[31]) begin
			idx_n = '0;
		end else if (e_idx > 32'(szm1)) begin
			idx_n = szm1;
		end else begin
			idx_n = e_idx[SIZE_W-1:0];
		end

		pm      = 57'(idx_q[j_q]) * 57'(blk_q[j_q]);
		pm_c    = (pm > 57'(POS_CAP)) ? POS_CAP : pm[POS_W-1:0];
		pos_sum = {1'b0, pos_q} + {1'b0, pm_c};
		bm      = 57'(b_q) * 57'(size_j);
		bm_c    = (bm > 57'(POS_CAP)) ? POS_CAP : bm[POS_W-1:0];
		p_sel   = nbr_q ? ({1'b0, pos_q} + {1'b0, blk_q[j_q]}) : {1'b0, pos_q};

		rd_a = bit_q[AW+4:5];
		rd_b = rd_a + AW'(1);

		both    = {rd_hi_q, lov_q ? rd_lo_q : 32'd0};
		shv     = both << sh_q;
		ext_val = shv[63:32] >> (6'd32 - bps_eff);

		enc33  = enc_q[j_q];
		samp33 = $signed({1'b0, sample_q});
		zprod  = enc33 * samp33;
		idx_sh = 64'(idx_q[j_q]) << FRAC_BITS;
		fr64   = 64'(enc_q[j_q]) - $signed(idx_sh);
		// fraction is negative when the coordinate extrapolates below zero
		frac33 = $signed(fr64[32:0]);
		diff33 = $signed({1'b0, s2_q}) - samp33;
		nprod  = frac33 * diff33;

		nsum = 65'(acc_q) + 65'(prod_q);
		if (nsum[64] != nsum[63]) begin
			nsat = nsum[64] ? I64_MIN : I64_MAX;
		end else begin
			nsat = nsum[63:0];
		end

		accc = (acc_q < ACC_LO) ? ACC_LO : ((acc_q > ACC_HI) ? ACC_HI : acc_q);
		m1_full = eh_q * ch_gain;
		el_s    = $signed({1'b0, el_q});
		m2_n    = el_s * ch_gain;

		r_a   = m1_q;
		r_b   = m2_q >>> FRAC_BITS;
		r_c   = ch_min;
		r_sum = r_a + r_b + r_c;
		if (r_sum > 67'sh7fff_ffff) begin
			r_cl = 32'sh7fff_ffff;
		end else if (r_sum < -67'sh8000_0000) begin
			r_cl = 32'sh8000_0000;
		end else begin
			r_cl = r_sum[31:0];
		end
	end

	assign pop = take;

	always_ff @(posedge clk) begin
		if (take && cmd.func == FN_SAMPLE) begin
			mem[AW'(cmd.slot)] <= cmd.coef_a;
		end
		if (state_q == S_RD) begin
			rd_hi_q <= mem[rd_a];
			rd_lo_q <= mem[rd_b];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd_q <= cmd;
					pos_q <= '0;
					b_q   <= POS_W'(1);
				end
			end
			S_MUL: prod_q <= mul_e;
			S_ENC: begin
				enc_q[j_q] <= e_cl;
				idx_q[j_q] <= idx_n;
				blk_q[j_q] <= b_q;
			end
			S_POS: pos_q <= (pos_sum > {1'b0, POS_CAP}) ? POS_CAP : pos_sum[POS_W-1:0];
			S_BLK: b_q <= bm_c;
			S_LIN: lin_q <= LIN_W'(p_sel) * LIN_W'(no_eff) + LIN_W'(ch_q);
			S_BIT: bit_q <= BIT_W'(lin_q) * BIT_W'(bps_eff);
			S_RD: begin
				oob_q <= (64'(bit_q) + 64'(bps_eff)) > TOTAL_BITS;
				lov_q <= (64'(bit_q >> 5) + 64'd1) < 64'(SAMPLE_WORDS);
				sh_q  <= bit_q[4:0];
			end
			S_EXT: begin
				if (!nbr_q) begin
					sample_q <= oob_q ? 32'd0 : ext_val;
					acc_q    <= $signed({32'd0, oob_q ? 32'd0 : ext_val}) <<< FRAC_BITS;
				end else begin
					s2_q <= oob_q ? 32'd0 : ext_val;
				end
			end
			S_ZMUL: acc_q <= zprod[63:0];
			S_NMUL: prod_q <= nprod[63:0];
			S_NADD: acc_q <= nsat;
			S_DEC1: begin
				eh_q <= 33'(accc >>> FRAC_BITS);
				el_q <= accc[FRAC_BITS-1:0];
			end
			S_DEC2: m1_q <= m1_full[63:0];
			S_DEC3: m2_q <= m2_n;
			S_DEC4: res_q <= err_q ? 32'sd0 : r_cl;
			default: ;
		endcase
	end

	// control, tables and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bps_q   <= 6'd8;
			nin_q   <= 3'd1;
			nout_q  <= 3'd1;
			j_q     <= '0;
			ch_q    <= '0;
			nbr_q   <= 1'b0;
			err_q   <= 1'b0;
			res     <= '0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				dim_size_q[i] <= SIZE_W'(1);
				dim_gain_q[i] <= '0;
				dim_off_q[i]  <= '0;
			end
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				out_min_q[i]  <= '0;
				out_gain_q[i] <= '0;
			end
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					CFG_BPS:  bps_q  <= cfg.data;
					CFG_NIN:  nin_q  <= cfg.data[2:0];
					CFG_NOUT: nout_q <= cfg.data[2:0];
					default: ;
				endcase
			end
			if (res.valid && res_ready && !emit) begin
				res.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (cmd.func)
							FN_DIM: begin
								dim_size_q[DIM_W'(cmd.slot)] <= cmd.size;
								dim_gain_q[DIM_W'(cmd.slot)] <= cmd.coef_a;
								dim_off_q[DIM_W'(cmd.slot)]  <= cmd.coef_b;
							end
							FN_OUT: begin
								out_min_q[CH_W'(cmd.slot)]  <= cmd.coef_a;
								out_gain_q[CH_W'(cmd.slot)] <= cmd.coef_b;
							end
							FN_EVAL: begin
								j_q     <= '0;
								state_q <= S_MUL;
							end
							default: ;
						endcase
					end
				end
				S_MUL: state_q <= S_ENC;
				S_ENC: state_q <= S_POS;
				S_POS: state_q <= S_BLK;
				S_BLK: begin
					if (dim_end) begin
						ch_q    <= '0;
						state_q <= S_CH;
					end else begin
						j_q     <= j_q + DIM_W'(1);
						state_q <= S_MUL;
					end
				end
				S_CH: begin
					nbr_q   <= 1'b0;
					err_q   <= 1'b0;
					state_q <= S_LIN;
				end
				S_LIN: state_q <= S_BIT;
				S_BIT: state_q <= S_RD;
				S_RD:  state_q <= S_EXT;
				S_EXT: begin
					if (!nbr_q) begin
						err_q   <= oob_q;
						j_q     <= '0;
						state_q <= S_DIM;
					end else begin
						if (oob_q) begin
							err_q <= 1'b1;
						end
						state_q <= S_NMUL;
					end
				end
				S_DIM: begin
					if (idx_q[j_q] == szm1) begin
						state_q <= (idx_q[j_q] == '0) ? S_ZMUL : S_NEXT;
					end else begin
						nbr_q   <= 1'b1;
						state_q <= S_LIN;
					end
				end
				S_ZMUL: state_q <= S_NEXT;
				S_NMUL: state_q <= S_NADD;
				S_NADD: state_q <= S_NEXT;
				S_NEXT: begin
					if (dim_end) begin
						state_q <= S_DEC1;
					end else begin
						j_q     <= j_q + DIM_W'(1);
						state_q <= S_DIM;
					end
				end
				S_DEC1: state_q <= S_DEC2;
				S_DEC2: state_q <= S_DEC3;
				S_DEC3: state_q <= S_DEC4;
				S_DEC4: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit) begin
						res.valid   <= 1'b1;
						res.channel <= 2'(ch_q);
						res.value   <= res_q;
						res.last    <= ch_end;
						res.error   <= err_q;
						if (ch_end) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_CH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.error |-> res.value == '0)
		else $error("flagged word carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && (!res.valid || res_ready) && ch_end |=> state_q == S_IDLE)
		else $error("sequencer did not return after the final channel");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POS |-> idx_q[j_q] <= szm1)
		else $error("index beyond dimension size");

endmodule

### rtl/core/sampled_function_interpolator_top.sv
// Top level of the sampled function interpolator.
// Input words carry a function code in s_tuser: sample word writes, dimension and output
// table writes are applied by the back end when idle; writes to slots beyond the memory or
// tables are dropped. An evaluate word returns one result word per channel in use,
// tlast on the final one. Evaluation is done by a single sequencer that uses one
// registered two-word read of the sample memory for every sample fetch. A four-entry
// queue lets input words keep arriving while the sequencer works, and the output
// register lets the next channel proceed while a result waits.
// Sample memory has no reset; every word must be written before it is read.
module sampled_function_interpolator_top #(
	parameter int MAX_DIMS     = 4,
	parameter int MAX_CHANNELS = 4,
	parameter int SAMPLE_WORDS = 4096,
	parameter int FRAC_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// slot, dim_size_value, coef_a, coef_b, coord_0, coord_1, coord_2, coord_3
	input  logic [sfi_pkg::IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// channel, result_value
	output logic [sfi_pkg::OUT_DATA_W-1:0] m_tdata,
	// error
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [sfi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfi_pkg::*;

	cmd_t    f_cmd, q_cmd;
	logic    f_push, b_pop;
	q_stat_t q_stat;
	cfg_wr_t cfg;
	res_t    res;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sfi_front #(
		.MAX_DIMS    (MAX_DIMS),
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_WORDS(SAMPLE_WORDS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_stat  (q_stat),
		.push    (f_push),
		.cmd     (f_cmd)
	);

	sfi_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.din   (f_cmd),
		.pop   (b_pop),
		.dout  (q_cmd),
		.stat  (q_stat)
	);

	sfi_back #(
		.MAX_DIMS    (MAX_DIMS),
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_WORDS(SAMPLE_WORDS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (q_cmd),
		.q_stat   (q_stat),
		.pop      (b_pop),
		.res      (res),
		.res_ready(m_tready)
	);

	assign m_tvalid = res.valid;
	assign m_tdata  = {6'd0, res.value, res.channel};
	assign m_tuser  = res.error;
	assign m_tlast  = res.last;

endmodule

### sim/tb.sv
// Testbench for the sampled function interpolator: stream stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb;
	import sfi_pkg::*;

	localparam int  N_WORDS    = 4096;
	localparam int  FRAC       = 16;
	localparam int  N_DIMS     = 4;
	localparam int  N_CHANS    = 4;
	localparam int  SETTLE     = 300;
	localparam int  STALL_MAX  = 20000;
	localparam int  PRELOAD    = 65;
	localparam longint unsigned SPAN_CAP  = 64'h100_0000_0000;
	localparam longint unsigned MEM_BITS  = 64'd131072;

	typedef struct {
		func_t       func;
		logic [11:0] slot;
		logic [15:0] size;
		logic [31:0] coef_a;
		logic [31:0] coef_b;
		logic [31:0] coord [4];
	} cmd_word_t;

	typedef struct {
		logic [1:0]  channel;
		logic [31:0] value;
		logic        last;
		logic        error;
	} result_word_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sampled_function_interpolator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// shadow of the block state
	logic [31:0] mem_img [N_WORDS];
	logic [15:0] tbl_size [N_DIMS];
	logic [31:0] tbl_gain [N_DIMS];
	logic [31:0] tbl_offs [N_DIMS];
	logic [31:0] tbl_omin [N_CHANS];
	logic [31:0] tbl_ogain [N_CHANS];
	logic [5:0]  reg_bps;
	logic [2:0]  reg_nin, reg_nout;

	cmd_word_t     cmd_q [$];
	result_word_t  result_q [$];
	int send_idle_pct, recv_idle_pct;
	int mismatches, n_evals, n_results, n_errors, stall_cnt;
	bit in_taken;

	function automatic longint sat_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (a >= 0 && b >= 0 && s < 0) return 64'sh7fff_ffff_ffff_ffff;
		if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
		return s;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint unsigned span_mul(longint unsigned a, longint unsigned b);
		longint unsigned p;
		if (a == 0 || b == 0) return 0;
		if (a > SPAN_CAP / b) return SPAN_CAP;
		p = a * b;
		return p > SPAN_CAP ? SPAN_CAP : p;
	endfunction

	function automatic int clamp_count(int v, int maxv);
		return v == 0 ? 1 : (v > maxv ? maxv : v);
	endfunction

	function automatic logic [31:0] fetch_sample(longint unsigned bitpos, int n);
		longint unsigned w;
		logic [63:0] both;
		w = bitpos >> 5;
		both[63:32] = w < N_WORDS ? mem_img[w] : 32'd0;
		both[31:0]  = (w + 1) < N_WORDS ? mem_img[w + 1] : 32'd0;
		both = both << bitpos[4:0];
		return 32'(both >> (64 - n));
	endfunction

	// expected result words of one evaluate word
	function automatic void interpolate(cmd_word_t c);
		longint enc [N_DIMS];
		longint unsigned idx [N_DIMS], blk [N_DIMS], sz [N_DIMS];
		longint unsigned pos, b, base, nb;
		longint e, acc, frac, g, eh, el, r;
		int nd, no, bps;
		logic [31:0] smp, s2;
		bit err;
		result_word_t rw;
		nd = clamp_count(reg_nin, N_DIMS);
		no = clamp_count(reg_nout, N_CHANS);
		bps = clamp_count(reg_bps, 32);
		pos = 0;
		b = 1;
		for (int j = 0; j < nd; j++) begin
			e = (longint'($signed(c.coord[j])) * longint'($signed(tbl_gain[j]))) >>> FRAC;
			e = clip(e + longint'($signed(tbl_offs[j])), -64'sd2147483648, 64'sd2147483647);
			enc[j] = e;
			sz[j] = tbl_size[j] != 0 ? tbl_size[j] : 1;
			blk[j] = b;
			idx[j] = e < 0 ? 0 : longint'(e >> FRAC);
			if (idx[j] > sz[j] - 1) idx[j] = sz[j] - 1;
			pos += span_mul(idx[j], blk[j]);
			if (pos > SPAN_CAP) pos = SPAN_CAP;
			b = span_mul(b, sz[j]);
		end
		for (int ch = 0; ch < no; ch++) begin
			base = (pos * no + ch) * bps;
			err = base + bps > MEM_BITS;
			smp = err ? 32'd0 : fetch_sample(base, bps);
			acc = longint'(smp) <<< FRAC;
			for (int j = 0; j < nd; j++) begin
				if (idx[j] == sz[j] - 1) begin
					// size-one axis: scale the sample by the encoded coordinate
					if (idx[j] == 0) acc = enc[j] * longint'(smp);
				end else begin
					nb = ((pos + blk[j]) * no + ch) * bps;
					s2 = 32'd0;
					frac = enc[j] - longint'(idx[j] << FRAC);
					if (nb + bps > MEM_BITS) err = 1'b1;
					else s2 = fetch_sample(nb, bps);
					acc = sat_sum(acc, frac * (longint'(s2) - longint'(smp)));
				end
			end
			rw.value = 32'd0;
			if (!err) begin
				g = longint'($signed(tbl_ogain[ch]));
				acc = clip(acc, -(64'sd1 <<< 47), (64'sd1 <<< 48) - 1);
				eh = acc >>> FRAC;
				el = acc & 64'hffff;
				r = sat_sum(eh * g, (el * g) >>> FRAC);
				r = sat_sum(r, longint'($signed(tbl_omin[ch])));
				rw.value = 32'(clip(r, -64'sd2147483648, 64'sd2147483647));
			end
			rw.channel = 2'(ch);
			rw.last = (ch == no - 1);
			rw.error = err;
			result_q.push_back(rw);
		end
	endfunction

	function automatic void absorb(cmd_word_t c);
		case (c.func)
			FN_SAMPLE: if (c.slot < N_WORDS) mem_img[c.slot] = c.coef_a;
			FN_DIM: if (c.slot < N_DIMS) begin
				tbl_size[c.slot] = c.size;
				tbl_gain[c.slot] = c.coef_a;
				tbl_offs[c.slot] = c.coef_b;
			end
			FN_OUT: if (c.slot < N_CHANS) begin
				tbl_omin[c.slot] = c.coef_a;
				tbl_ogain[c.slot] = c.coef_b;
			end
			default: begin
				interpolate(c);
				n_evals++;
			end
		endcase
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		cmd_word_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
			if (!s_tvalid || in_taken) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					c = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= c.func;
					s_tdata <= {4'd0, c.coord[3], c.coord[2], c.coord[1], c.coord[0],
						c.coef_b, c.coef_a, c.size, c.slot};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			in_taken = 1'b0;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cmd_word_t c;
		result_word_t rw;
		bit busy;
		busy = 1'b0;
		if (arst_n && s_tvalid && s_tready) begin
			c.func = func_t'(s_tuser);
			{c.coord[3], c.coord[2], c.coord[1], c.coord[0], c.coef_b, c.coef_a, c.size,
				c.slot} = s_tdata[219:0];
			absorb(c);
			in_taken = 1'b1;
			busy = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			busy = 1'b1;
			n_results++;
			if (m_tuser[0]) n_errors++;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: ch %0d value %h", m_tdata[1:0],
						m_tdata[33:2]);
			end else begin
				rw = result_q.pop_front();
				if (rw.channel !== m_tdata[1:0] || rw.value !== m_tdata[33:2]
						|| rw.last !== m_tlast || rw.error !== m_tuser[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ch %0d val %h last %b err %b, got ch %0d val %h last %b err %b",
							rw.channel, rw.value, rw.last, rw.error,
							m_tdata[1:0], m_tdata[33:2], m_tlast, m_tuser[0]);
				end
			end
		end
		stall_cnt = busy ? 0 : stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("watchdog: no handshake for %0d cycles", STALL_MAX);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [31:0] mixed_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h3_0000);
			2: begin
				case ($urandom_range(3))
					0: return 32'h0;
					1: return 32'hffff_ffff;
					2: return 32'h8000_0000;
					default: return 32'h7fff_ffff;
				endcase
			end
			default: return 32'($urandom_range(32'h6_0000)) - 32'h1_0000;
		endcase
	endfunction

	task automatic push_cmd(func_t f, logic [11:0] slot, logic [15:0] size,
			logic [31:0] a, logic [31:0] b, logic [31:0] c0, logic [31:0] c1 = $urandom,
			logic [31:0] c2 = $urandom, logic [31:0] c3 = $urandom);
		cmd_word_t c;
		c.func = f;
		c.slot = slot;
		c.size = size;
		c.coef_a = a;
		c.coef_b = b;
		c.coord[0] = c0;
		c.coord[1] = c1;
		c.coord[2] = c2;
		c.coord[3] = c3;
		cmd_q.push_back(c);
	endtask

	task automatic push_random();
		int pick;
		logic [11:0] slot;
		logic [15:0] size;
		pick = $urandom_range(99);
		slot = $urandom_range(7) == 0 ? 12'($urandom) : 12'($urandom_range(3));
		case ($urandom_range(5))
			0: size = 16'($urandom);
			1: size = $urandom_range(1) ? 16'hffff : 16'h0;
			default: size = $urandom_range(1, 6);
		endcase
		// real dimensions stay at most two wide so every read lands in the preloaded words
		if (slot < N_DIMS) size = 16'($urandom_range(2));
		if (pick < 20)
			push_cmd(FN_SAMPLE, 12'($urandom), 16'($urandom), mixed_word(), $urandom, $urandom);
		else if (pick < 35)
			push_cmd(FN_DIM, slot, size,
				$urandom_range(1) ? 32'h1_0000 : mixed_word(), mixed_word(), $urandom);
		else if (pick < 45)
			push_cmd(FN_OUT, slot, 16'($urandom), mixed_word(), mixed_word(), $urandom);
		else
			push_cmd(FN_EVAL, 12'($urandom), 16'($urandom), $urandom, $urandom,
				mixed_word(), mixed_word(), mixed_word(), mixed_word());
	endtask

	task automatic settle();
		wait (cmd_q.size() == 0 && !s_tvalid && result_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [5:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_BPS:  reg_bps = val;
			CFG_NIN:  reg_nin = val[2:0];
			CFG_NOUT: reg_nout = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	int unsigned cfg_list [8][3] = '{'{1, 4, 4}, '{32, 4, 4}, '{0, 0, 0}, '{63, 7, 7},
		'{12, 2, 3}, '{24, 3, 2}, '{16, 4, 1}, '{2, 1, 4}};

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_taken = 1'b0;
		mismatches = 0;
		n_evals = 0;
		n_results = 0;
		n_errors = 0;
		stall_cnt = 0;
		send_idle_pct = 29;
		recv_idle_pct = 51;
		foreach (mem_img[i]) mem_img[i] = '0;
		for (int i = 0; i < N_DIMS; i++) begin
			tbl_size[i] = 16'd1;
			tbl_gain[i] = '0;
			tbl_offs[i] = '0;
		end
		for (int i = 0; i < N_CHANS; i++) begin
			tbl_omin[i] = '0;
			tbl_ogain[i] = '0;
		end
		reg_bps = 6'd8;
		reg_nin = 3'd1;
		reg_nout = 3'd1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// low words cover every in-range read: at most 16 positions x 4 channels x 32 bits;
		// larger sizes below only ever reach past the end of memory
		for (int w = 0; w < PRELOAD; w++)
			push_cmd(FN_SAMPLE, 12'(w), 16'($urandom), $urandom_range(7) == 0 ?
				32'hffff_ffff : $urandom, $urandom, $urandom);
		settle();

		// directed part at reset register values
		push_cmd(FN_DIM, 12'd0, 16'd5, 32'h1_0000, 32'h0, 32'h0);
		push_cmd(FN_OUT, 12'd0, 16'd0, 32'h0, 32'h1_0000, 32'h0);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h0);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h1_8000);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'hffff_0000);  // extrapolates below 0
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h7fff_ffff);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h8000_0000);
		push_cmd(FN_DIM, 12'd0, 16'd1, 32'h8000, 32'h4000, 32'h0);     // size-one axis
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h3_0000);
		push_cmd(FN_DIM, 12'd0, 16'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h7fff_ffff);
		push_cmd(FN_DIM, 12'hfff, 16'hffff, 32'h1234_5678, 32'h1, 32'h0);  // dropped
		push_cmd(FN_OUT, 12'hfff, 16'hffff, 32'h7fff_ffff, 32'h1, 32'h0);  // dropped
		push_cmd(FN_SAMPLE, 12'hfff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		push_cmd(FN_SAMPLE, 12'd0, 16'h0, 32'h0, 32'h0, 32'h0);
		push_cmd(FN_OUT, 12'd0, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		push_cmd(FN_DIM, 12'd0, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h7fff_ffff);   // beyond memory
		push_cmd(FN_OUT, 12'd0, 16'd0, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
		push_cmd(FN_DIM, 12'd0, 16'd3, 32'h1_0000, 32'h0, 32'h0);
		push_cmd(FN_EVAL, 12'd0, 16'd0, 32'h0, 32'h0, 32'h1_ffff);
		push_cmd(FN_EVAL, 12'hfff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		settle();

		for (int k = 0; k < 8; k++) begin
			if (k == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 29;
			end else if (k == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_BPS, 6'(cfg_list[k][0]));
			write_reg(CFG_NIN, 6'(cfg_list[k][1]));
			write_reg(CFG_NOUT, 6'(cfg_list[k][2]));
			// load sane tables before the random mix
			for (int d = 0; d < N_DIMS; d++)
				push_cmd(FN_DIM, 12'(d), 16'($urandom_range(1, 2)), 32'h1_0000,
					32'($urandom_range(32'hffff)), $urandom);
			for (int o = 0; o < N_CHANS; o++)
				push_cmd(FN_OUT, 12'(o), 16'($urandom), mixed_word(), mixed_word(), $urandom);
			repeat (29) push_random();
			settle();
		end

		$display("%0d evaluations, %0d result words (%0d flagged out of memory), 8 register settings",
			n_evals, n_results, n_errors);
		$display("%0d mismatches, %0d result words still expected", mismatches, result_q.size());
		if (mismatches == 0 && result_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
